// ----- hdl/ir_pulse_width_word_receiver_defines.svh -----
// ----------------------------------------------------------------------------
// IR pulse-width word receiver assertion macros
// Shared property forms used by the receiver checker.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_WORD_RECEIVER_DEFINES_SVH
`define IR_PULSE_WIDTH_WORD_RECEIVER_DEFINES_SVH

// Same-cycle implication that is checked only outside reset.
`define IRPW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked only outside reset.
`define IRPW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define IRPW_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/irpw_pkg.sv -----
// ----------------------------------------------------------------------------
// IR pulse-width word receiver package
// Phase codes, per-channel state, window settings and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irpw_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SIGN = 3'd1,
    PH_GAP  = 3'd2,
    PH_DATA = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        expect_rising;
    logic [31:0] last_edge_time;
    logic [31:0] shift_word;
  } chan_state_t;

  typedef struct packed {
    logic [15:0] sign_min;
    logic [15:0] sign_max;
    logic [15:0] gap_min;
    logic [15:0] gap_max;
    logic [15:0] one_min;
    logic [15:0] one_max;
    logic [15:0] zero_min;
    logic [15:0] zero_max;
  } window_cfg_t;

  localparam logic [2:0] CFG_SIGN_MIN = 3'd0;
  localparam logic [2:0] CFG_SIGN_MAX = 3'd1;
  localparam logic [2:0] CFG_GAP_MIN  = 3'd2;
  localparam logic [2:0] CFG_GAP_MAX  = 3'd3;
  localparam logic [2:0] CFG_ONE_MIN  = 3'd4;
  localparam logic [2:0] CFG_ONE_MAX  = 3'd5;
  localparam logic [2:0] CFG_ZERO_MIN = 3'd6;
  localparam logic [2:0] CFG_ZERO_MAX = 3'd7;

  localparam logic MODE_EDGE  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  function automatic logic in_window(input logic [31:0] dur, input logic [15:0] lo,
                                     input logic [15:0] hi);
    return (dur >= {16'd0, lo}) && (dur <= {16'd0, hi});
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ir_pulse_width_word_receiver.sv -----
// A fetch word fills the input registers, then its answer the result registers;
// edge words produce no answer. Throughput: one word per cycle unless a fetch
// waits on a stalled result, limited by the single read-modify-write of the
// addressed channel's state registers between the input and result registers.
// Reset: synchronous; clears every channel to idle and loads the window defaults.
// ----------------------------------------------------------------------------
// IR pulse-width word receiver
// Multi-channel infrared frame decoder driven by timestamped edges, with fetch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_width_word_receiver import irpw_pkg::*; #(
  parameter int NUM_CHANNELS = 6,
  parameter int WORD_BITS    = 32,
  parameter int QUIET_US     = 10000,
  parameter int MISS_LIMIT   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        mode,
  input  logic [2:0]  channel,
  input  logic        rising,
  input  logic [31:0] time_us,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  out_channel,
  output logic        word_ready,
  output logic [31:0] word,
  output logic        power_cycle,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int BCW = $clog2(WORD_BITS + 1);
  localparam int MCW = $clog2(MISS_LIMIT + 1);

  window_cfg_t    win;
  chan_state_t    chan [NUM_CHANNELS];
  logic [BCW-1:0] bits [NUM_CHANNELS];
  logic [MCW-1:0] miss [NUM_CHANNELS];

  logic           s1_valid;
  logic           s1_mode;
  logic [2:0]     s1_channel;
  logic           s1_rising;
  logic [31:0]    s1_time;
  logic           s1_advance;
  logic           s1_in_range;
  logic [CHW-1:0] sel;

  chan_state_t    nxt;
  logic [BCW-1:0] nxt_bits;
  logic [MCW-1:0] nxt_miss;
  logic           upd_ready;
  logic [31:0]    upd_word;
  logic           upd_power;

  assign cfg_ready   = 1'b1;
  assign s1_in_range = 32'(s1_channel) < 32'(NUM_CHANNELS);
  assign sel         = CHW'(s1_channel);
  assign s1_advance  = s1_valid && ((s1_mode == MODE_EDGE) || !result_valid || !result_stall);
  assign item_stall  = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.sign_min <= 16'd0;
      win.sign_max <= 16'hFFFF;
      win.gap_min  <= 16'd0;
      win.gap_max  <= 16'hFFFF;
      win.one_min  <= 16'd0;
      win.one_max  <= 16'hFFFF;
      win.zero_min <= 16'd0;
      win.zero_max <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIGN_MIN: win.sign_min <= cfg_data;
        CFG_SIGN_MAX: win.sign_max <= cfg_data;
        CFG_GAP_MIN:  win.gap_min  <= cfg_data;
        CFG_GAP_MAX:  win.gap_max  <= cfg_data;
        CFG_ONE_MIN:  win.one_min  <= cfg_data;
        CFG_ONE_MAX:  win.one_max  <= cfg_data;
        CFG_ZERO_MIN: win.zero_min <= cfg_data;
        CFG_ZERO_MAX: win.zero_max <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
    if (!item_stall && item_valid) begin
      s1_mode    <= mode;
      s1_channel <= channel;
      s1_rising  <= rising;
      s1_time    <= time_us;
    end
  end

  irpw_chan_update #(
    .WORD_BITS  (WORD_BITS),
    .QUIET_US   (QUIET_US),
    .MISS_LIMIT (MISS_LIMIT),
    .BCW        (BCW),
    .MCW        (MCW)
  ) u_update (
    .cur         (chan[sel]),
    .cur_bits    (bits[sel]),
    .cur_miss    (miss[sel]),
    .win         (win),
    .mode        (s1_mode),
    .rising      (s1_rising),
    .time_us     (s1_time),
    .nxt         (nxt),
    .nxt_bits    (nxt_bits),
    .nxt_miss    (nxt_miss),
    .word_ready  (upd_ready),
    .word        (upd_word),
    .power_cycle (upd_power)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan[i].phase          <= PH_IDLE;
        chan[i].expect_rising  <= 1'b0;
        chan[i].last_edge_time <= '0;
        chan[i].shift_word     <= '0;
        bits[i]                <= '0;
        miss[i]                <= '0;
      end
    end else if (s1_advance && s1_in_range) begin
      chan[sel] <= nxt;
      bits[sel] <= nxt_bits;
      miss[sel] <= nxt_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance && (s1_mode == MODE_FETCH)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (s1_advance && (s1_mode == MODE_FETCH)) begin
      out_channel <= s1_channel;
      word_ready  <= s1_in_range && upd_ready;
      word        <= s1_in_range ? upd_word : '0;
      power_cycle <= s1_in_range && upd_power;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/irpw_chan_update.sv -----
// ----------------------------------------------------------------------------
// IR pulse-width channel update
// Next-state and fetch answer for the one channel that a word addresses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irpw_chan_update import irpw_pkg::*; #(
  parameter int WORD_BITS  = 32,
  parameter int QUIET_US   = 10000,
  parameter int MISS_LIMIT = 16,
  parameter int BCW        = 6,
  parameter int MCW        = 5
) (
  input  chan_state_t      cur,
  input  logic [BCW-1:0]   cur_bits,
  input  logic [MCW-1:0]   cur_miss,
  input  window_cfg_t      win,
  input  logic             mode,
  input  logic             rising,
  input  logic [31:0]      time_us,
  output chan_state_t      nxt,
  output logic [BCW-1:0]   nxt_bits,
  output logic [MCW-1:0]   nxt_miss,
  output logic             word_ready,
  output logic [31:0]      word,
  output logic             power_cycle
);

  logic [31:0] dur;
  logic [31:0] bit_mask;
  logic        bit_room;
  logic        last_bit;
  logic        miss_over;

  assign dur       = time_us - cur.last_edge_time;
  assign bit_mask  = 32'd1 << cur_bits;
  assign bit_room  = 32'(cur_bits) < 32'(WORD_BITS);
  assign last_bit  = (32'(cur_bits) + 32'd1) >= 32'(WORD_BITS);
  assign miss_over = (32'(cur_miss) + 32'd1) > 32'(MISS_LIMIT);

  always_comb begin
    nxt         = cur;
    nxt_bits    = cur_bits;
    nxt_miss    = cur_miss;
    word_ready  = 1'b0;
    word        = '0;
    power_cycle = 1'b0;
    if (mode == MODE_EDGE) begin
      if (rising == cur.expect_rising) begin
        nxt.last_edge_time = time_us;
        unique case (cur.phase)
          PH_SIGN: begin
            if (in_window(dur, win.sign_min, win.sign_max)) begin
              nxt.phase         = PH_GAP;
              nxt.expect_rising = 1'b0;
            end else begin
              nxt.phase         = PH_IDLE;
              nxt.shift_word    = '0;
              nxt_bits          = '0;
              nxt.expect_rising = 1'b0;
            end
          end
          PH_GAP: begin
            if (in_window(dur, win.gap_min, win.gap_max)) begin
              nxt.phase         = PH_DATA;
              nxt.expect_rising = 1'b1;
            end else begin
              nxt.phase         = PH_IDLE;
              nxt.shift_word    = '0;
              nxt_bits          = '0;
              nxt.expect_rising = 1'b0;
            end
          end
          PH_DATA: begin
            priority if (bit_room && in_window(dur, win.one_min, win.one_max)) begin
              nxt.shift_word    = cur.shift_word | bit_mask;
              nxt_bits          = cur_bits + BCW'(1);
              nxt.expect_rising = 1'b0;
              nxt.phase         = last_bit ? PH_DONE : PH_GAP;
            end else if (bit_room && in_window(dur, win.zero_min, win.zero_max)) begin
              nxt.shift_word    = cur.shift_word & ~bit_mask;
              nxt_bits          = cur_bits + BCW'(1);
              nxt.expect_rising = 1'b0;
              nxt.phase         = last_bit ? PH_DONE : PH_GAP;
            end else begin
              nxt.phase         = PH_IDLE;
              nxt.shift_word    = '0;
              nxt_bits          = '0;
              nxt.expect_rising = 1'b0;
            end
          end
          PH_DONE: begin
            if (dur >= 32'(QUIET_US)) begin
              nxt.phase         = PH_SIGN;
              nxt.expect_rising = 1'b1;
              nxt.shift_word    = '0;
              nxt_bits          = '0;
            end
          end
          default: begin
            nxt.phase         = PH_SIGN;
            nxt.expect_rising = 1'b1;
          end
        endcase
      end
    end else begin
      if (cur.phase == PH_DONE) begin
        word_ready        = 1'b1;
        word              = cur.shift_word;
        nxt.phase         = PH_IDLE;
        nxt.shift_word    = '0;
        nxt_bits          = '0;
        nxt.expect_rising = 1'b0;
        nxt_miss          = '0;
      end else if (miss_over) begin
        nxt_miss    = '0;
        power_cycle = 1'b1;
      end else begin
        nxt_miss = cur_miss + MCW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/irpw_checker.sv -----
// ----------------------------------------------------------------------------
// IR pulse-width word receiver checker
// Port-level properties of the receiver, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ir_pulse_width_word_receiver_defines.svh"

module irpw_checker #(
  parameter int NUM_CHANNELS = 6
) (
  input wire        clk,
  input wire        rst,
  input wire        result_valid,
  input wire        result_stall,
  input wire [2:0]  out_channel,
  input wire        word_ready,
  input wire [31:0] word,
  input wire        power_cycle
);

  `IRPW_ASSERT_NOW(a_ready_no_power, clk, rst, result_valid && word_ready, !power_cycle, "Word with power cycle.")
  `IRPW_ASSERT_NOW(a_miss_zero_word, clk, rst, result_valid && !word_ready, word == 32'd0, "Miss with data.")
  `IRPW_ASSERT_NOW(a_bad_channel_quiet, clk, rst, result_valid && (32'(out_channel) >= 32'(NUM_CHANNELS)), !word_ready && !power_cycle, "Bad channel answered.")
  `IRPW_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(word) && $stable(out_channel), "Stalled word changed.")
  `IRPW_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !result_valid, "Result after reset.")

endmodule

bind ir_pulse_width_word_receiver irpw_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_checker (.*);

`default_nettype wire

// ----- tb/tb_ir_pulse_width_word_receiver.sv -----
// ----------------------------------------------------------------------------
// IR pulse-width word receiver testbench
// Drives timestamped edges and fetches into the receiver under several window
// settings. A behavioral model of every channel predicts each fetch answer, and
// a checker compares the answers field by field as they leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ir_pulse_width_word_receiver;
  import irpw_pkg::*;

  localparam int NCH            = 6;
  localparam int WBITS          = 32;
  localparam int QUIET          = 10000;
  localparam int MISS_LIM       = 16;
  localparam int GAP_PCT        = 30;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [2:0]  chan;
    logic        ready;
    logic [31:0] data;
    logic        pwr;
  } fetch_answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        mode = MODE_EDGE;
  logic [2:0]  channel = 3'd0;
  logic        rising = 1'b0;
  logic [31:0] time_us = 32'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  out_channel;
  logic        word_ready;
  logic [31:0] word;
  logic        power_cycle;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_SIGN_MIN;
  logic [15:0] cfg_data = 16'd0;

  fetch_answer_t answers_due[$];
  phase_t        rx_phase [NCH];
  logic          rx_rising [NCH];
  logic [31:0]   rx_last [NCH];
  logic [31:0]   rx_word [NCH];
  int unsigned   rx_bits [NCH];
  int unsigned   rx_misses [NCH];
  window_cfg_t   win;

  int errors = 0;
  int idle_cycles = 0;
  int focus_ch = 0;
  bit gaps_on = 1'b1;

  ir_pulse_width_word_receiver #(
    .NUM_CHANNELS(NCH),
    .WORD_BITS(WBITS),
    .QUIET_US(QUIET),
    .MISS_LIMIT(MISS_LIM)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .mode(mode),
    .channel(channel),
    .rising(rising),
    .time_us(time_us),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_channel(out_channel),
    .word_ready(word_ready),
    .word(word),
    .power_cycle(power_cycle),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic bit in_range(logic [31:0] d, logic [15:0] lo, logic [15:0] hi);
    return (d >= 32'(lo)) && (d <= 32'(hi));
  endfunction

  function automatic void drop_channel(logic [2:0] ch);
    rx_phase[ch] = PH_IDLE;
    rx_word[ch] = 32'd0;
    rx_bits[ch] = 0;
    rx_rising[ch] = 1'b0;
  endfunction

  // Updates the channel model for one accepted word and queues the answer of a fetch.
  function automatic void predict_word(logic m, logic [2:0] ch, logic r, logic [31:0] t);
    fetch_answer_t a;
    logic [31:0]   d;
    bit            hit_one;
    bit            hit_zero;
    if (m == MODE_EDGE) begin
      if (ch < NCH && r == rx_rising[ch]) begin
        d = t - rx_last[ch];
        rx_last[ch] = t;
        case (rx_phase[ch])
          PH_SIGN: begin
            if (in_range(d, win.sign_min, win.sign_max)) begin
              rx_phase[ch] = PH_GAP;
              rx_rising[ch] = 1'b0;
            end else begin
              drop_channel(ch);
            end
          end
          PH_GAP: begin
            if (in_range(d, win.gap_min, win.gap_max)) begin
              rx_phase[ch] = PH_DATA;
              rx_rising[ch] = 1'b1;
            end else begin
              drop_channel(ch);
            end
          end
          PH_DATA: begin
            hit_one = in_range(d, win.one_min, win.one_max);
            hit_zero = in_range(d, win.zero_min, win.zero_max);
            if (!hit_one && !hit_zero) begin
              drop_channel(ch);
            end else begin
              rx_word[ch][rx_bits[ch]] = hit_one;
              rx_bits[ch]++;
              rx_rising[ch] = 1'b0;
              if (rx_bits[ch] >= WBITS) rx_phase[ch] = PH_DONE;
              else rx_phase[ch] = PH_GAP;
            end
          end
          PH_DONE: begin
            if (d >= QUIET) begin
              rx_phase[ch] = PH_SIGN;
              rx_rising[ch] = 1'b1;
              rx_word[ch] = 32'd0;
              rx_bits[ch] = 0;
            end
          end
          default: begin
            rx_phase[ch] = PH_SIGN;
            rx_rising[ch] = 1'b1;
          end
        endcase
      end
    end else begin
      a.chan = ch;
      a.ready = 1'b0;
      a.data = 32'd0;
      a.pwr = 1'b0;
      if (ch < NCH) begin
        if (rx_phase[ch] == PH_DONE) begin
          a.ready = 1'b1;
          a.data = rx_word[ch];
          drop_channel(ch);
          rx_misses[ch] = 0;
        end else begin
          rx_misses[ch]++;
          if (rx_misses[ch] > MISS_LIM) begin
            rx_misses[ch] = 0;
            a.pwr = 1'b1;
          end
        end
      end
      answers_due.push_back(a);
    end
  endfunction

  function automatic logic [31:0] pick_duration(logic [15:0] lo, logic [15:0] hi);
    if (lo <= hi) return $urandom_range(hi, lo);
    return $urandom_range(65535);
  endfunction

  task automatic send_word(logic m, logic [2:0] ch, logic r, logic [31:0] t);
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    mode <= m;
    channel <= ch;
    rising <= r;
    time_us <= t;
    do @(posedge clk); while (item_stall);
    predict_word(m, ch, r, t);
  endtask

  task automatic wait_for_answers();
    @(negedge clk);
    item_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SIGN_MIN: win.sign_min = val;
      CFG_SIGN_MAX: win.sign_max = val;
      CFG_GAP_MIN:  win.gap_min = val;
      CFG_GAP_MAX:  win.gap_max = val;
      CFG_ONE_MIN:  win.one_min = val;
      CFG_ONE_MAX:  win.one_max = val;
      CFG_ZERO_MIN: win.zero_min = val;
      default:      win.zero_max = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_windows(logic [15:0] s_lo, logic [15:0] s_hi, logic [15:0] g_lo,
                              logic [15:0] g_hi, logic [15:0] o_lo, logic [15:0] o_hi,
                              logic [15:0] z_lo, logic [15:0] z_hi);
    wait_for_answers();
    write_reg(CFG_SIGN_MIN, s_lo);
    write_reg(CFG_SIGN_MAX, s_hi);
    write_reg(CFG_GAP_MIN, g_lo);
    write_reg(CFG_GAP_MAX, g_hi);
    write_reg(CFG_ONE_MIN, o_lo);
    write_reg(CFG_ONE_MAX, o_hi);
    write_reg(CFG_ZERO_MIN, z_lo);
    write_reg(CFG_ZERO_MAX, z_hi);
  endtask

  // Mostly well-formed frames on one channel at a time, with other channels,
  // stray fetches and a little noise mixed in.
  task automatic run_frames(int count);
    int          n;
    int          c;
    int          roll;
    bit          was_done;
    logic [31:0] d;
    logic [31:0] t;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < 80) c = focus_ch;
      else c = $urandom_range(NCH - 1);
      roll = $urandom_range(999);
      if (roll < 10) begin
        send_word(MODE_EDGE, 3'($urandom_range(7, NCH)), 1'($urandom), $urandom);
      end else if (roll < 20) begin
        send_word(MODE_FETCH, 3'($urandom_range(7, NCH)), 1'($urandom), $urandom);
      end else if (roll < 35) begin
        send_word(MODE_EDGE, 3'(c), ~rx_rising[c], $urandom);
      end else if (roll < 42) begin
        send_word(MODE_EDGE, 3'(c), rx_rising[c], $urandom);
      end
      was_done = (rx_phase[c] == PH_DONE);
      if ((was_done && $urandom_range(1)) || $urandom_range(99) < 2) begin
        send_word(MODE_FETCH, 3'(c), 1'($urandom), $urandom);
        if (was_done && c == focus_ch) focus_ch = $urandom_range(NCH - 1);
      end else begin
        case (rx_phase[c])
          PH_SIGN: d = pick_duration(win.sign_min, win.sign_max);
          PH_GAP:  d = pick_duration(win.gap_min, win.gap_max);
          PH_DATA: begin
            if ($urandom_range(1)) d = pick_duration(win.one_min, win.one_max);
            else d = pick_duration(win.zero_min, win.zero_max);
          end
          PH_DONE: begin
            case ($urandom_range(3))
              0: d = QUIET - 1;
              1: d = QUIET;
              2: d = $urandom_range(QUIET - 1);
              default: d = $urandom_range(QUIET + 100000, QUIET);
            endcase
          end
          default: d = 32'd0;
        endcase
        if (rx_phase[c] == PH_IDLE) t = $urandom;
        else t = rx_last[c] + d;
        send_word(MODE_EDGE, 3'(c), rx_rising[c], t);
      end
    end
  endtask

  task automatic test_edge_cases();
    send_word(MODE_FETCH, 3'd0, 1'b0, 32'd0);
    send_word(MODE_FETCH, 3'd6, 1'b0, 32'd0);
    send_word(MODE_FETCH, 3'd7, 1'b1, 32'hFFFF_FFFF);
    send_word(MODE_EDGE, 3'd6, 1'b1, 32'd0);
    send_word(MODE_EDGE, 3'd7, 1'b0, 32'hFFFF_FFFF);
    send_word(MODE_EDGE, 3'd1, 1'b1, 32'd5);
    send_word(MODE_EDGE, 3'd1, 1'b0, 32'hFFFF_FFF0);
    send_word(MODE_EDGE, 3'd1, 1'b0, 32'd0);
    // The signature pulse crosses the wrap of the timestamp.
    send_word(MODE_EDGE, 3'd1, 1'b1, 32'h0000_000F);
    send_word(MODE_EDGE, 3'd1, 1'b0, 32'h0001_000F);
    send_word(MODE_EDGE, 3'd1, 1'b0, 32'd0);
    send_word(MODE_EDGE, 3'd1, 1'b1, 32'd65535);
    send_word(MODE_EDGE, 3'd1, 1'b0, 32'd65535);
    send_word(MODE_EDGE, 3'd1, 1'b1, 32'd65635);
    send_word(MODE_FETCH, 3'd1, 1'b0, 32'd0);
    send_word(MODE_EDGE, 3'd1, 1'b0, 32'd131171);
    send_word(MODE_FETCH, 3'd1, 1'b1, 32'd0);
  endtask

  task automatic test_miss_limit();
    int n;
    for (n = 0; n < 36; n++) send_word(MODE_FETCH, 3'd2, 1'($urandom), $urandom);
  endtask

  task automatic test_frames_back_to_back();
    gaps_on = 1'b0;
    run_frames(150);
    wait_for_answers();
    gaps_on = 1'b1;
  endtask

  task automatic test_frames_narrow();
    load_windows(16'd4000, 16'd5000, 16'd400, 16'd700, 16'd1500, 16'd1800, 16'd500, 16'd650);
    run_frames(150);
    wait_for_answers();
    run_frames(150);
  endtask

  task automatic test_frames_extreme_windows();
    load_windows(16'd0, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0);
    run_frames(150);
  endtask

  task automatic test_empty_windows();
    load_windows(16'd0, 16'd65535, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd65535);
    run_frames(100);
    wait_for_answers();
    write_reg(CFG_SIGN_MIN, 16'd65535);
    write_reg(CFG_SIGN_MAX, 16'd0);
    run_frames(50);
  endtask

  task automatic test_random_windows();
    int          r;
    logic [15:0] lo [4];
    logic [15:0] hi [4];
    for (r = 0; r < 2; r++) begin
      foreach (lo[i]) begin
        lo[i] = 16'($urandom_range(32767));
        hi[i] = 16'(lo[i] + $urandom_range(32768));
      end
      load_windows(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2], lo[3], hi[3]);
      run_frames(80);
    end
  endtask

  function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(negedge clk) begin
    result_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
  end

  always @(posedge clk) begin
    fetch_answer_t a;
    if (!rst && result_valid && !result_stall) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected answer, expected none, actual channel %0d word %h",
                 $time, out_channel, word);
        errors++;
      end else begin
        a = answers_due.pop_front();
        compare_field("out_channel", 32'(a.chan), 32'(out_channel));
        compare_field("word_ready", 32'(a.ready), 32'(word_ready));
        compare_field("word", a.data, word);
        compare_field("power_cycle", 32'(a.pwr), 32'(power_cycle));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NCH; i++) begin
      rx_phase[i] = PH_IDLE;
      rx_rising[i] = 1'b0;
      rx_last[i] = 32'd0;
      rx_word[i] = 32'd0;
      rx_bits[i] = 0;
      rx_misses[i] = 0;
    end
    win = '0;
    win.sign_max = 16'hFFFF;
    win.gap_max = 16'hFFFF;
    win.one_max = 16'hFFFF;
    win.zero_max = 16'hFFFF;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_edge_cases();
    test_miss_limit();
    test_frames_back_to_back();
    test_frames_narrow();
    test_frames_extreme_windows();
    test_empty_windows();
    test_random_windows();
    wait_for_answers();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/irpw_pkg.sv
hdl/irpw_chan_update.sv
hdl/ir_pulse_width_word_receiver.sv
hdl/irpw_checker.sv
tb/tb_ir_pulse_width_word_receiver.sv
